// File: rtl/tclm_pkg.sv
`default_nettype none
package tclm_pkg;

	localparam int unsigned TimeW   = 64;
	localparam int unsigned RegW    = 32;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned FracW   = 32;
	localparam int unsigned StepW   = 5;

	localparam logic [CfgIdxW-1:0] RegWindowLength = 1'b0;
	localparam logic [CfgIdxW-1:0] RegTickInterval = 1'b1;

	localparam logic [RegW-1:0]  TickIntervalReset = 32'd1;
	localparam logic [FracW-1:0] LoadFull          = 32'hffff_ffff;
	localparam logic [StepW-1:0] LastStep          = 5'd31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_ELAPSE,
		ST_CHECK,
		ST_BUSY,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		SUB_ELAPSE,
		SUB_CLAMP,
		SUB_BUSY,
		SUB_DIV
	} sub_sel_t;

endpackage
`default_nettype wire

// File: rtl/tick_cpu_load_meter.sv
// An accepted word runs through ACCUM, ELAPSE and CHECK to DONE when no window closes,
// also through BUSY when a fully busy window closes, and through BUSY and DIV when the busy share
// is divided out (one setup step and 32 restoring-division steps on one 64-bit subtractor).
// The input stalls while a word is in work; a new word is taken only once the last has left DONE.
// The finished result sits in an output register, so a stalled output holds only the end step.
// Reset (arst_n low, asynchronous) clears tick count, window start, sleep sum and load,
// sets window_length to 0 and the timer period to 1.
`default_nettype none
module tick_cpu_load_meter (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [tclm_pkg::TimeW-1:0]            now_time,
	input  wire logic [tclm_pkg::RegW-1:0]             sleep_delta,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [tclm_pkg::TimeW-1:0]                 tick_number,
	output logic [tclm_pkg::TimeW-1:0]                 next_deadline,
	output logic [tclm_pkg::FracW-1:0]                 busy_fraction,
	output logic                                       window_closed,
	output logic [tclm_pkg::TimeW-1:0]                 sleep_in_window,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [tclm_pkg::CfgIdxW-1:0]          cfg_index,
	input  wire logic [tclm_pkg::RegW-1:0]             cfg_data
);

	tclm_pkg::state_t state_q, state_d;
	tclm_pkg::sub_sel_t sub_sel;

	logic [tclm_pkg::RegW-1:0]  window_length_q, timer_period_q;
	logic [tclm_pkg::TimeW-1:0] tick_count_q, window_start_q, sleep_acc_q;
	logic [tclm_pkg::FracW-1:0] load_q, quot_q;
	logic [tclm_pkg::TimeW-1:0] now_q, deadline_q, elapsed_q, slept_q, rem_q;
	logic [tclm_pkg::RegW-1:0]  delta_q;
	logic [tclm_pkg::StepW-1:0] step_q;
	logic                       closed_q;

	logic [tclm_pkg::TimeW-1:0] out_tick_q, out_deadline_q, out_slept_q;
	logic [tclm_pkg::FracW-1:0] out_load_q;
	logic                       out_closed_q, out_valid_q;

	logic [tclm_pkg::TimeW-1:0] sub_a, sub_b, rem_shift;
	logic [tclm_pkg::TimeW:0]   sub_diff, acc_sum;
	logic                       sub_borrow, div_take, window_due, accept, emit;

	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign emit      = (state_q == tclm_pkg::ST_DONE) && (!out_valid_q || !out_stall);

	// Shared 64-bit subtractor; the borrow doubles as the comparator
	assign rem_shift = {rem_q[tclm_pkg::TimeW-2:0], 1'b0};
	always_comb begin
		case (sub_sel)
			tclm_pkg::SUB_ELAPSE: begin
				sub_a = now_q;
				sub_b = window_start_q;
			end
			tclm_pkg::SUB_CLAMP: begin
				sub_a = elapsed_q;
				sub_b = sleep_acc_q;
			end
			tclm_pkg::SUB_BUSY: begin
				sub_a = elapsed_q;
				sub_b = slept_q;
			end
			tclm_pkg::SUB_DIV: begin
				sub_a = rem_shift;
				sub_b = elapsed_q;
			end
			default: begin
				sub_a = rem_shift;
				sub_b = elapsed_q;
			end
		endcase
	end
	assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_borrow = sub_diff[tclm_pkg::TimeW];
	assign div_take   = rem_q[tclm_pkg::TimeW-1] || !sub_borrow;

	assign acc_sum    = {1'b0, sleep_acc_q} + {{(tclm_pkg::TimeW-tclm_pkg::RegW+1){1'b0}}, delta_q};
	assign window_due = (window_length_q != '0) &&
		(elapsed_q >= {{(tclm_pkg::TimeW-tclm_pkg::RegW){1'b0}}, window_length_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			tclm_pkg::ST_IDLE:   if (in_valid) begin
				state_d = tclm_pkg::ST_ACCUM;
			end
			tclm_pkg::ST_ACCUM:  state_d = tclm_pkg::ST_ELAPSE;
			tclm_pkg::ST_ELAPSE: state_d = tclm_pkg::ST_CHECK;
			tclm_pkg::ST_CHECK:  state_d = window_due ? tclm_pkg::ST_BUSY : tclm_pkg::ST_DONE;
			tclm_pkg::ST_BUSY:   state_d = (slept_q == '0) ? tclm_pkg::ST_DONE : tclm_pkg::ST_DIV;
			tclm_pkg::ST_DIV:    if (step_q == tclm_pkg::LastStep) begin
				state_d = tclm_pkg::ST_DONE;
			end
			tclm_pkg::ST_DONE:   if (emit) begin
				state_d = tclm_pkg::ST_IDLE;
			end
			default:             state_d = tclm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		sub_sel  = tclm_pkg::SUB_DIV;
		case (state_q)
			tclm_pkg::ST_IDLE:   in_stall = 1'b0;
			tclm_pkg::ST_ELAPSE: sub_sel  = tclm_pkg::SUB_ELAPSE;
			tclm_pkg::ST_CHECK:  sub_sel  = tclm_pkg::SUB_CLAMP;
			tclm_pkg::ST_BUSY:   sub_sel  = tclm_pkg::SUB_BUSY;
			default:             sub_sel  = tclm_pkg::SUB_DIV;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= tclm_pkg::ST_IDLE;
			window_length_q <= '0;
			timer_period_q  <= tclm_pkg::TickIntervalReset;
			tick_count_q    <= '0;
			window_start_q  <= '0;
			sleep_acc_q     <= '0;
			load_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tclm_pkg::RegWindowLength: window_length_q <= cfg_data;
					tclm_pkg::RegTickInterval: timer_period_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == tclm_pkg::ST_ACCUM) begin
				tick_count_q <= tick_count_q + 64'd1;
				// saturate the sleep sum rather than wrap
				sleep_acc_q  <= acc_sum[tclm_pkg::TimeW] ? '1 : acc_sum[tclm_pkg::TimeW-1:0];
			end
			if (state_q == tclm_pkg::ST_BUSY && slept_q == '0) begin
				load_q <= tclm_pkg::LoadFull;
			end
			if (state_q == tclm_pkg::ST_DIV && step_q == tclm_pkg::LastStep) begin
				load_q <= {quot_q[tclm_pkg::FracW-2:0], div_take};
			end
			if (emit && closed_q) begin
				sleep_acc_q    <= '0;
				window_start_q <= now_q;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q   <= now_time;
			delta_q <= sleep_delta;
		end
		case (state_q)
			tclm_pkg::ST_ACCUM: begin
				deadline_q <= now_q + {{(tclm_pkg::TimeW-tclm_pkg::RegW){1'b0}}, timer_period_q};
				closed_q   <= 1'b0;
				slept_q    <= '0;
			end
			tclm_pkg::ST_ELAPSE: elapsed_q <= sub_diff[tclm_pkg::TimeW-1:0];
			tclm_pkg::ST_CHECK: if (window_due) begin
				// clamp sleep to the elapsed time of the window
				slept_q  <= sub_borrow ? elapsed_q : sleep_acc_q;
				closed_q <= 1'b1;
			end
			tclm_pkg::ST_BUSY: begin
				rem_q  <= sub_diff[tclm_pkg::TimeW-1:0];
				quot_q <= '0;
				step_q <= '0;
			end
			tclm_pkg::ST_DIV: begin
				rem_q  <= div_take ? sub_diff[tclm_pkg::TimeW-1:0] : rem_shift;
				quot_q <= {quot_q[tclm_pkg::FracW-2:0], div_take};
				step_q <= step_q + 5'd1;
			end
			default: ;
		endcase
		if (emit) begin
			out_tick_q     <= tick_count_q;
			out_deadline_q <= deadline_q;
			out_load_q     <= load_q;
			out_closed_q   <= closed_q;
			out_slept_q    <= slept_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign tick_number     = out_tick_q;
	assign next_deadline   = out_deadline_q;
	assign busy_fraction   = out_load_q;
	assign window_closed   = out_closed_q;
	assign sleep_in_window = out_slept_q;

endmodule
`default_nettype wire
